// ----- design/fcw_pkg.sv -----
// ----------------------------------------------------------------------------
// fcw_pkg
// Shared types and constants of the FAT16 cluster chain walker.
// ----------------------------------------------------------------------------
package fcw_pkg;

   localparam int FAT_ENTRIES_DEF  = 4096;
   localparam int MAX_SEGMENTS_DEF = 64;

   // request field layout in req_tdata
   localparam int REQ_DATA_W    = 112;
   localparam int IDX_LSB       = 0;
   localparam int IDX_W         = 12;
   localparam int VAL_LSB       = 12;
   localparam int VAL_W         = 16;
   localparam int START_LSB     = 28;
   localparam int START_W       = 16;
   localparam int SIZE_LSB      = 44;
   localparam int LEN_LSB       = 76;
   localparam int LEN_W         = 32;

   localparam int RSP_DATA_W    = 48;
   localparam int CSR_ADDR_W    = 4;

   localparam logic ACT_WRITE = 1'b0;
   localparam logic ACT_WALK  = 1'b1;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_FREE    = 2'd1;
   localparam logic [1:0] ST_OUTSIDE = 2'd2;
   localparam logic [1:0] ST_LIMIT   = 2'd3;

   localparam logic [1:0] REG_CLUSTER_BYTES = 2'd0;
   localparam logic [1:0] REG_DATA_BASE     = 2'd1;
   localparam logic [1:0] REG_END_MARK      = 2'd2;

   typedef struct packed {
      logic [15:0] cluster_bytes;
      logic [31:0] data_base;
      logic [15:0] chain_end_mark;
   } cfg_type;

   typedef struct packed {
      logic        wr_en;
      logic        rd_en;
      logic [15:0] addr;
      logic [15:0] wdata;
   } tbl_req_type;

endpackage

// ----- design/fcw_table.sv -----
// ----------------------------------------------------------------------------
// fcw_table
// Single-port allocation table memory with registered read data.
// ----------------------------------------------------------------------------
module fcw_table #(
   parameter int FAT_ENTRIES = fcw_pkg::FAT_ENTRIES_DEF
) (
   input  logic                clock,
   input  fcw_pkg::tbl_req_type tbl_req,
   output logic [15:0]         rdata
);

   localparam int AW = $clog2(FAT_ENTRIES);

   logic [15:0] mem [FAT_ENTRIES];
   logic [15:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (tbl_req.wr_en) begin
         mem[tbl_req.addr[AW-1:0]] <= tbl_req.wdata;
      end
      if (tbl_req.rd_en) begin
         rdata_ff <= mem[tbl_req.addr[AW-1:0]];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ----- design/fcw_walker.sv -----
// ----------------------------------------------------------------------------
// fcw_walker
// Request sequencer: table writes, chain walk and the result register.
// ----------------------------------------------------------------------------
module fcw_walker #(
   parameter int FAT_ENTRIES  = fcw_pkg::FAT_ENTRIES_DEF,
   parameter int MAX_SEGMENTS = fcw_pkg::MAX_SEGMENTS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  fcw_pkg::cfg_type              cfg,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [fcw_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic                          req_tuser,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [fcw_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic [1:0]                    rsp_tuser,
   output logic                          rsp_tlast,
   output fcw_pkg::tbl_req_type          tbl_req,
   input  logic [15:0]                   tbl_rdata
);

   localparam int SW = $clog2(MAX_SEGMENTS + 1);
   localparam logic [16:0] ENTRIES_LIM = 17'(FAT_ENTRIES);
   localparam logic [SW-1:0] SEG_LAST = SW'(MAX_SEGMENTS - 1);
   localparam int RSP_DATA_W_L = fcw_pkg::RSP_DATA_W;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_READ = 2'd1;
   localparam logic [1:0] S_EMIT = 2'd2;

   logic [1:0]    state_ff, state_in;
   logic [15:0]   cluster_ff, cluster_in;
   logic [31:0]   remaining_ff, remaining_in;
   logic [SW-1:0] seg_ff, seg_in;
   logic [31:0]   product_ff, product_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W_L-1:0] rsp_data_ff, rsp_data_in;
   logic [1:0]    rsp_status_ff, rsp_status_in;
   logic          rsp_last_ff, rsp_last_in;

   logic [11:0] req_idx;
   logic [15:0] req_val;
   logic [15:0] req_start;
   logic [31:0] req_size;
   logic [31:0] req_len;
   logic        accept;
   logic        slot_free;
   logic        full_seg;
   logic        outside;

   assign req_idx   = req_tdata[fcw_pkg::IDX_LSB +: fcw_pkg::IDX_W];
   assign req_val   = req_tdata[fcw_pkg::VAL_LSB +: fcw_pkg::VAL_W];
   assign req_start = req_tdata[fcw_pkg::START_LSB +: fcw_pkg::START_W];
   assign req_size  = req_tdata[fcw_pkg::SIZE_LSB +: fcw_pkg::LEN_W];
   assign req_len   = req_tdata[fcw_pkg::LEN_LSB +: fcw_pkg::LEN_W];

   assign req_tready = (state_ff == S_IDLE) && !reset;
   assign accept     = req_tvalid && req_tready;
   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign full_seg   = remaining_ff >= {16'd0, cfg.cluster_bytes};
   assign outside    = {1'b0, cluster_ff} >= ENTRIES_LIM;

   always_comb begin
      state_in      = state_ff;
      cluster_in    = cluster_ff;
      remaining_in  = remaining_ff;
      seg_in        = seg_ff;
      product_in    = product_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;
      tbl_req       = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_tuser == fcw_pkg::ACT_WRITE) begin
                  tbl_req.wr_en = ({5'd0, req_idx} < ENTRIES_LIM);
                  tbl_req.addr  = {4'd0, req_idx};
                  tbl_req.wdata = req_val;
               end else begin
                  cluster_in   = req_start;
                  remaining_in = (req_size < req_len) ? req_size : req_len;
                  seg_in       = '0;
                  state_in     = S_READ;
               end
            end
         end
         S_READ: begin
            tbl_req.rd_en = !outside;
            tbl_req.addr  = cluster_ff;
            product_in    = 32'(cluster_ff) * 32'(cfg.cluster_bytes);
            state_in      = S_EMIT;
         end
         S_EMIT: begin
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_data_in   = {cfg.cluster_bytes, cfg.data_base + product_ff};
               rsp_status_in = fcw_pkg::ST_OK;
               rsp_last_in   = 1'b1;
               state_in      = S_IDLE;
               if (!full_seg) begin
                  rsp_data_in[47:32] = remaining_ff[15:0];
               end else if (outside) begin
                  rsp_status_in = fcw_pkg::ST_OUTSIDE;
               end else if (tbl_rdata == 16'd0) begin
                  rsp_status_in = fcw_pkg::ST_FREE;
               end else if (tbl_rdata == cfg.chain_end_mark) begin
                  rsp_status_in = fcw_pkg::ST_OK;
               end else if (seg_ff == SEG_LAST) begin
                  rsp_status_in = fcw_pkg::ST_LIMIT;
               end else begin
                  rsp_last_in  = 1'b0;
                  cluster_in   = tbl_rdata;
                  remaining_in = remaining_ff - {16'd0, cfg.cluster_bytes};
                  seg_in       = seg_ff + SW'(1);
                  state_in     = S_READ;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cluster_ff    <= cluster_in;
      remaining_ff  <= remaining_in;
      seg_ff        <= seg_in;
      product_ff    <= product_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ----- design/fat16_cluster_chain_walker.sv -----
// ----------------------------------------------------------------------------
// fat16_cluster_chain_walker
// Keeps a FAT16 allocation table and walks cluster chains into byte segments.
// ----------------------------------------------------------------------------
//  port group | direction | carries
//  req_*      | in        | table write or chain walk request
//  rsp_*      | out       | one segment per beat, tlast on the final one
//  csr_*      | in/out    | cluster_bytes, data_base, chain_end_mark
//
//  A table write is done as it is accepted. A walk takes two steps per segment
//  (table read plus offset multiply, then emit), for up to MAX_SEGMENTS segments,
//  and no new request is taken until the walk ends.
//  Reset clears control and loads the register defaults; table contents are
//  undefined until written. A stalled result holds the walk in place.
// ----------------------------------------------------------------------------
module fat16_cluster_chain_walker #(
   parameter int FAT_ENTRIES  = fcw_pkg::FAT_ENTRIES_DEF,
   parameter int MAX_SEGMENTS = fcw_pkg::MAX_SEGMENTS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // entry_index, entry_value, start_cluster, file_size, requested_length
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [fcw_pkg::REQ_DATA_W-1:0]  req_tdata,
   // action
   input  logic                            req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // byte_offset, byte_count
   output logic [fcw_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // status
   output logic [1:0]                      rsp_tuser,
   output logic                            rsp_tlast,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [fcw_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [31:0]                     csr_pwdata,
   output logic [31:0]                     csr_prdata,
   output logic                            csr_pready
);

   logic [15:0] cluster_bytes_ff, cluster_bytes_in;
   logic [31:0] data_base_ff, data_base_in;
   logic [15:0] end_mark_ff, end_mark_in;
   logic        csr_wr;
   logic [1:0]  csr_idx;

   fcw_pkg::cfg_type     cfg;
   fcw_pkg::tbl_req_type tbl_req;
   logic [15:0]          tbl_rdata;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_idx    = csr_paddr[3:2];

   always_comb begin
      cluster_bytes_in = cluster_bytes_ff;
      data_base_in     = data_base_ff;
      end_mark_in      = end_mark_ff;
      if (csr_wr) begin
         unique case (csr_idx)
            fcw_pkg::REG_CLUSTER_BYTES: cluster_bytes_in = csr_pwdata[15:0];
            fcw_pkg::REG_DATA_BASE:     data_base_in     = csr_pwdata;
            fcw_pkg::REG_END_MARK:      end_mark_in      = csr_pwdata[15:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         fcw_pkg::REG_CLUSTER_BYTES: csr_prdata = {16'd0, cluster_bytes_ff};
         fcw_pkg::REG_DATA_BASE:     csr_prdata = data_base_ff;
         fcw_pkg::REG_END_MARK:      csr_prdata = {16'd0, end_mark_ff};
         default:                    csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cluster_bytes_ff <= 16'd512;
         data_base_ff     <= 32'd0;
         end_mark_ff      <= 16'hFFFF;
      end else begin
         cluster_bytes_ff <= cluster_bytes_in;
         data_base_ff     <= data_base_in;
         end_mark_ff      <= end_mark_in;
      end
   end

   assign cfg.cluster_bytes  = cluster_bytes_ff;
   assign cfg.data_base      = data_base_ff;
   assign cfg.chain_end_mark = end_mark_ff;

   fcw_walker #(
      .FAT_ENTRIES  (FAT_ENTRIES),
      .MAX_SEGMENTS (MAX_SEGMENTS)
   ) u_walker (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .tbl_req    (tbl_req),
      .tbl_rdata  (tbl_rdata)
   );

   fcw_table #(
      .FAT_ENTRIES (FAT_ENTRIES)
   ) u_table (
      .clock   (clock),
      .tbl_req (tbl_req),
      .rdata   (tbl_rdata)
   );

endmodule
